[hdl/rotation_matrix_to_euler_angles_assert.svh]
// Assertion macros shared by the checker of the rotation matrix to Euler angle block.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_ASSERT_SVH

// Checked property with reset masking.
`define RMTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define RMTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rmte_pkg.sv]
// Types, constants and the arctangent table of the rotation matrix to Euler angle block.
package rmte_pkg;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
  } rmte_in_t;

  typedef struct packed {
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic [1:0]         singular_case;
  } rmte_out_t;

  localparam logic signed [31:0] DEG90  = 32'sd754974720;
  localparam logic signed [31:0] DEG180 = 32'sd1509949440;

  localparam logic [1:0] SING_NONE  = 2'd0;
  localparam logic [1:0] SING_PLUS  = 2'd1;
  localparam logic [1:0] SING_MINUS = 2'd2;

  localparam int SQRT_STAGES = 32;

  function automatic logic [31:0] atan_deg(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd377487360;
      1:  v = 32'd222843801;
      2:  v = 32'd117744544;
      3:  v = 32'd59768969;
      4:  v = 32'd30000467;
      5:  v = 32'd15014858;
      6:  v = 32'd7509261;
      7:  v = 32'd3754861;
      8:  v = 32'd1877459;
      9:  v = 32'd938733;
      10: v = 32'd469367;
      11: v = 32'd234683;
      12: v = 32'd117342;
      13: v = 32'd58671;
      14: v = 32'd29335;
      15: v = 32'd14668;
      16: v = 32'd7334;
      17: v = 32'd3667;
      18: v = 32'd1833;
      19: v = 32'd917;
      20: v = 32'd458;
      21: v = 32'd229;
      22: v = 32'd115;
      23: v = 32'd57;
      24: v = 32'd29;
      25: v = 32'd14;
      26: v = 32'd7;
      27: v = 32'd4;
      28: v = 32'd2;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/rmte_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
module rmte_isqrt import rmte_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] val_in,
  output logic [31:0] root_out
);

  logic [63:0] rem_r  [0:SQRT_STAGES-1];
  logic [31:0] root_r [0:SQRT_STAGES-1];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - j;
    logic [63:0] rem_prev;
    logic [31:0] root_prev;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign rem_prev  = val_in;
      assign root_prev = 32'd0;
    end else begin : g_next
      assign rem_prev  = rem_r[j-1];
      assign root_prev = root_r[j-1];
    end

    assign trial = ({32'd0, root_prev} << (B + 1)) + (64'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_prev >= trial) begin
          rem_r[j]  <= rem_prev - trial;
          root_r[j] <= root_prev | (32'd1 << B);
        end else begin
          rem_r[j]  <= rem_prev;
          root_r[j] <= root_prev;
        end
      end
    end
  end

  assign root_out = root_r[SQRT_STAGES-1];

endmodule

[hdl/rmte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2 in Q9.23 degrees.
module rmte_cordic import rmte_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] y_in,
  input  logic signed [33:0] x_in,
  output logic signed [31:0] z_out
);

  localparam int W  = 36;
  localparam int ZW = 34;

  logic signed [W-1:0]  x_r    [0:STAGES];
  logic signed [W-1:0]  y_r    [0:STAGES];
  logic signed [ZW-1:0] z_r    [0:STAGES];
  logic                 spec_r [0:STAGES];
  logic signed [31:0]   sval_r [0:STAGES];
  logic signed [31:0]   z_out_r;

  logic signed [W-1:0]  xe, ye, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 spec_nxt;
  logic signed [31:0]   sval_nxt;
  logic signed [31:0]   z_out_nxt;

  assign xe = W'(x_in);
  assign ye = W'(y_in);

  always_comb begin
    x_nxt    = xe;
    y_nxt    = ye;
    z_nxt    = '0;
    spec_nxt = 1'b0;
    sval_nxt = '0;
    if (ye == '0) begin
      spec_nxt = 1'b1;
      sval_nxt = (xe < 0) ? DEG180 : 32'sd0;
    end else if (xe == '0) begin
      spec_nxt = 1'b1;
      sval_nxt = (ye > 0) ? DEG90 : -DEG90;
    end else if (xe < 0) begin
      if (ye > 0) begin
        x_nxt = ye;
        y_nxt = -xe;
        z_nxt = ZW'(DEG90);
      end else begin
        x_nxt = -ye;
        y_nxt = xe;
        z_nxt = -ZW'(DEG90);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt;
      y_r[0]    <= y_nxt;
      z_r[0]    <= z_nxt;
      spec_r[0] <= spec_nxt;
      sval_r[0] <= sval_nxt;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] T = ZW'(atan_deg(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + T;
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - T;
        end
        spec_r[i+1] <= spec_r[i];
        sval_r[i+1] <= sval_r[i];
      end
    end
  end

  always_comb begin
    if (spec_r[STAGES]) begin
      z_out_nxt = sval_r[STAGES];
    end else if (z_r[STAGES] > ZW'(DEG180)) begin
      z_out_nxt = DEG180;
    end else if (z_r[STAGES] < -ZW'(DEG180)) begin
      z_out_nxt = -DEG180;
    end else begin
      z_out_nxt = z_r[STAGES][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_out_r <= z_out_nxt;
    end
  end

  assign z_out = z_out_r;

endmodule

[hdl/rotation_matrix_to_euler_angles.sv]
// Top level: rotation matrix to X, Y and Z Euler angles in a fixed-point pipeline.
//
//   channel | direction | handshake        | beat
//   in_     | input     | in_valid/stall   | seven Q2.30 matrix entries
//   out_    | output    | out_valid/stall  | three Q9.23 angles and a singular case code
//   cfg_    | input     | cfg_valid/ready  | angle tolerance in angle LSBs
//
// One beat is accepted per cycle while the output is not stalled. The pipeline runs through the
// 32-stage square root followed by the CORDIC stages and the output register.
// The synchronous active-low reset clears all valid bits and sets the tolerance to one.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
module rotation_matrix_to_euler_angles import rmte_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rmte_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rmte_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PRE = 3 + SQRT_STAGES;
  localparam int N   = PRE + CORDIC_STAGES + 3;

  logic           en;
  logic [N-1:0]   v_r;
  logic [15:0]    tol_r;
  rmte_in_t       side_r [0:PRE-1];
  logic [63:0]    prod_a_r, prod_b_r, sum_r;
  logic [31:0]    abs_a, abs_b, root;
  rmte_in_t       mid;
  logic signed [31:0] z_pitch, z_xreg, z_xsing, z_z;
  rmte_out_t      out_r, out_nxt;

  assign en        = !(v_r[N-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      tol_r <= 16'd1;
    end else begin
      if (en) begin
        v_r <= {v_r[N-2:0], in_valid};
      end
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
    end
  end

  assign abs_a = side_r[0].rot_00[31] ? (~side_r[0].rot_00 + 32'd1) : side_r[0].rot_00;
  assign abs_b = side_r[0].rot_10[31] ? (~side_r[0].rot_10 + 32'd1) : side_r[0].rot_10;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_data;
      for (int k = 1; k < PRE; k++) begin
        side_r[k] <= side_r[k-1];
      end
      prod_a_r <= 64'(abs_a) * 64'(abs_a);
      prod_b_r <= 64'(abs_b) * 64'(abs_b);
      sum_r    <= prod_a_r + prod_b_r;
    end
  end

  rmte_isqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .val_in   (sum_r),
    .root_out (root)
  );

  assign mid = side_r[PRE-1];

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (en),
    .y_in (-34'(mid.rot_20)), .x_in ({2'b00, root}), .z_out (z_pitch)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_xreg (
    .clk (clk), .en (en),
    .y_in (34'(mid.rot_21)), .x_in (34'(mid.rot_22)), .z_out (z_xreg)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_xsing (
    .clk (clk), .en (en),
    .y_in (34'(mid.rot_01)), .x_in (34'(mid.rot_11)), .z_out (z_xsing)
  );

  rmte_cordic #(.STAGES(CORDIC_STAGES)) u_z (
    .clk (clk), .en (en),
    .y_in (34'(mid.rot_10)), .x_in (34'(mid.rot_00)), .z_out (z_z)
  );

  always_comb begin
    logic signed [32:0] p;
    logic signed [32:0] tol;
    tol = {17'd0, tol_r};
    p   = 33'(z_pitch);
    if (p <= tol && p >= -tol) begin
      p = '0;
    end
    if (p >= 33'(DEG90) - tol) begin
      out_nxt.angle_x       = z_xsing;
      out_nxt.angle_y       = DEG90;
      out_nxt.angle_z       = '0;
      out_nxt.singular_case = SING_PLUS;
    end else if (p <= -33'(DEG90) + tol) begin
      out_nxt.angle_x       = -z_xsing;
      out_nxt.angle_y       = -DEG90;
      out_nxt.angle_z       = '0;
      out_nxt.singular_case = SING_MINUS;
    end else begin
      out_nxt.angle_x       = z_xreg;
      out_nxt.angle_y       = p[31:0];
      out_nxt.angle_z       = z_z;
      out_nxt.singular_case = SING_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v_r[N-1];
  assign out_data  = out_r;

endmodule

[hdl/rmte_checker.sv]
// Port-level checker for the rotation matrix to Euler angle block, with its bind.
`include "rotation_matrix_to_euler_angles_assert.svh"
module rmte_sva import rmte_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input rmte_out_t out_data
);

  logic singular;
  logic plus_case;

  assign singular  = out_valid && (out_data.singular_case != SING_NONE);
  assign plus_case = out_valid && (out_data.singular_case == SING_PLUS);

  `RMTE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "Stalled output beat dropped.")
  `RMTE_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "Stalled beat changed.")
  `RMTE_ASSERT(a_sing_z, singular |-> out_data.angle_z == 32'sd0, "Singular beat with non-zero Z.")
  `RMTE_ASSERT(a_sing_y, plus_case |-> out_data.angle_y == DEG90, "Plus-ninety case with wrong pitch.")
  `RMTE_ASSERT_ALWAYS(a_reset, !rst_n |=> !out_valid, "Output valid after reset.")

endmodule

bind rotation_matrix_to_euler_angles rmte_sva u_rmte_sva (.*);

[verif/rmte_checker.sv]
// Checker that predicts the Euler angles of each accepted matrix beat and compares the results.
module rmte_checker import rmte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  rmte_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rmte_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          singular_seen
);

  localparam int STAGES = 24;

  rmte_out_t   expected_angles[$];
  logic [15:0] tolerance;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint arctan_deg(input longint y, input longint x);
    longint z, t, dx, dy;
    z = 0;
    if (y == 0) return (x >= 0) ? 64'sd0 : longint'(DEG180);
    if (x == 0) return (y > 0) ? longint'(DEG90) : -longint'(DEG90);
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y; y = -t; z = DEG90;
      end else begin
        x = -y; y = t; z = -longint'(DEG90);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(atan_deg(i));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(atan_deg(i));
      end
    end
    if (z > DEG180) z = DEG180;
    if (z < -longint'(DEG180)) z = -longint'(DEG180);
    return z;
  endfunction

  function automatic rmte_out_t euler_angles(input rmte_in_t m, input logic [15:0] tol_in);
    rmte_out_t r;
    longint tol, pitch, c;
    longint unsigned a, b;
    tol = tol_in;
    a = (m.rot_00 < 0) ? -longint'(m.rot_00) : longint'(m.rot_00);
    b = (m.rot_10 < 0) ? -longint'(m.rot_10) : longint'(m.rot_10);
    c = root_floor(a * a + b * b);
    pitch = arctan_deg(-longint'(m.rot_20), c);
    if (pitch <= tol && pitch >= -tol) pitch = 0;
    if (pitch >= longint'(DEG90) - tol) begin
      r.angle_x = 32'(arctan_deg(m.rot_01, m.rot_11));
      r.angle_y = DEG90;
      r.angle_z = '0;
      r.singular_case = SING_PLUS;
    end else if (pitch <= -longint'(DEG90) + tol) begin
      r.angle_x = 32'(-arctan_deg(m.rot_01, m.rot_11));
      r.angle_y = -DEG90;
      r.angle_z = '0;
      r.singular_case = SING_MINUS;
    end else begin
      r.angle_x = 32'(arctan_deg(m.rot_21, m.rot_22));
      r.angle_y = 32'(pitch);
      r.angle_z = 32'(arctan_deg(m.rot_10, m.rot_00));
      r.singular_case = SING_NONE;
    end
    return r;
  endfunction

  assign pending = expected_angles.size();

  always @(posedge clk) begin
    rmte_out_t e;
    if (!rst_n) begin
      tolerance <= 16'd1;
      fail_count <= 0;
      results_seen <= 0;
      singular_seen <= 0;
      expected_angles.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (in_valid && !in_stall)
        expected_angles.insert(expected_angles.size(), euler_angles(in_data, tolerance));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (out_data.singular_case != SING_NONE) singular_seen <= singular_seen + 1;
        if (expected_angles.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result beat %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_angles.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10)
              $display("Mismatch: x %0d/%0d y %0d/%0d z %0d/%0d case %0d/%0d (exp/act)",
                       e.angle_x, out_data.angle_x, e.angle_y, out_data.angle_y,
                       e.angle_z, out_data.angle_z, e.singular_case, out_data.singular_case);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[verif/tb_rotation_matrix_to_euler_angles.sv]
// Testbench top: drives matrix beats and tolerance writes, and reports the verdict.
module tb_rotation_matrix_to_euler_angles;
  import rmte_pkg::*;

  localparam int LATENCY = 62;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rmte_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rmte_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count, pending, results_seen, singular_seen;
  int          cycle_count = 0;
  int          stall_mode = 0;

  always #6 clk = ~clk;

  rotation_matrix_to_euler_angles dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  rmte_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .singular_seen(singular_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) < 5);
    endcase
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
  end

  function automatic logic signed [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic rmte_in_t rand_matrix();
    rmte_in_t m;
    int sel;
    m.rot_00 = rand_entry(); m.rot_01 = rand_entry(); m.rot_10 = rand_entry();
    m.rot_11 = rand_entry(); m.rot_20 = rand_entry(); m.rot_21 = rand_entry();
    m.rot_22 = rand_entry();
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      m.rot_00 = $urandom_range(0, 64) - 32; m.rot_10 = $urandom_range(0, 64) - 32;
      m.rot_20 = (sel == 0) ? -32'sh4000_0000 : 32'sh4000_0000;
    end else if (sel < 4) begin
      m.rot_20 = $urandom_range(0, 64) - 32;
    end
    return m;
  endfunction

  task automatic send_matrix(input rmte_in_t m);
    in_data <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] value);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 1)) pause_sender();
        burst = $urandom_range(1, 20);
      end
      send_matrix(rand_matrix());
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rmte_in_t m;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    m = '0;
    send_matrix(m);
    m.rot_00 = 32'sh4000_0000; m.rot_11 = 32'sh4000_0000; m.rot_22 = 32'sh4000_0000;
    send_matrix(m);
    m = '0; m.rot_20 = -32'sh4000_0000; m.rot_01 = 32'sh2000_0000; m.rot_11 = 32'sh3000_0000;
    send_matrix(m);
    m.rot_20 = 32'sh4000_0000;
    send_matrix(m);
    m = '0; m.rot_00 = -32'sh4000_0000; m.rot_22 = -32'sh4000_0000; m.rot_21 = 32'sh1;
    send_matrix(m);
    m = '0; m.rot_10 = 32'sh4000_0000; m.rot_21 = -32'sh4000_0000;
    send_matrix(m);
    m = {7{32'sh8000_0000}};
    send_matrix(m);
    m = {7{32'sh7fff_ffff}};
    send_matrix(m);
    m = {7{32'shffff_ffff}};
    send_matrix(m);
    m = '0; m.rot_00 = 32'sh4000_0000; m.rot_20 = 32'sh2; m.rot_21 = -32'sh1;
    m.rot_22 = -32'sh1;
    send_matrix(m);
    pause_sender();
    random_phase(100);
    write_tolerance(16'd0);
    random_phase(100);
    write_tolerance(16'hffff);
    random_phase(100);
    write_tolerance(16'd300);
    random_phase(100);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d result beats, %0d of them singular, over four tolerance settings.",
             results_seen, singular_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[rotation_matrix_to_euler_angles.f]
+incdir+hdl
hdl/rmte_pkg.sv
hdl/rmte_isqrt.sv
hdl/rmte_cordic.sv
hdl/rotation_matrix_to_euler_angles.sv
hdl/rmte_checker.sv
verif/rmte_checker.sv
verif/tb_rotation_matrix_to_euler_angles.sv
